FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the ordered list engine RTL.
// Included by every module that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered list engine: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define OLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered list engine: assertion failed");

`endif

FILE: hw/rtl/ole_pkg.sv
// Package for the ordered list engine: sizes, operation and status codes,
// payload structs and the controller/datapath command and status structs.
// No dependencies.
package ole_pkg;

    // Sizes
    localparam int OLE_DEPTH = 16;
    localparam int OLE_AW    = $clog2(OLE_DEPTH);
    localparam int OLE_CW    = 5;
    localparam int OLE_DW    = 32;

    // Operation codes
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_INSERT     = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_POP_BACK   = 3'd4;
    localparam logic [2:0] OP_DELETE     = 3'd5;
    localparam logic [2:0] OP_DUMP       = 3'd6;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // Walk index selects
    localparam logic [2:0] IDX_HOLD    = 3'd0;
    localparam logic [2:0] IDX_ZERO    = 3'd1;
    localparam logic [2:0] IDX_ONE     = 3'd2;
    localparam logic [2:0] IDX_INC     = 3'd3;
    localparam logic [2:0] IDX_DEC     = 3'd4;
    localparam logic [2:0] IDX_LAST    = 3'd5;
    localparam logic [2:0] IDX_PIDX_P1 = 3'd6;

    // Insert/remove position selects
    localparam logic [2:0] POS_HOLD    = 3'd0;
    localparam logic [2:0] POS_ZERO    = 3'd1;
    localparam logic [2:0] POS_LEN     = 3'd2;
    localparam logic [2:0] POS_PIDX    = 3'd3;
    localparam logic [2:0] POS_PIDX_P1 = 3'd4;

    // Memory write selects
    localparam logic [1:0] WR_UP   = 2'd0;
    localparam logic [1:0] WR_DOWN = 2'd1;
    localparam logic [1:0] WR_VAL  = 2'd2;

    typedef struct packed {
        logic [2:0]               operation;
        logic signed [OLE_DW-1:0] value;
        logic signed [OLE_DW-1:0] target;
    } t_ole_in;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [OLE_DW-1:0] element;
        logic [OLE_CW-1:0]        count;
        logic                     last;
    } t_ole_out;

    typedef struct packed {
        logic       capture;
        logic       rd;
        logic [2:0] idx_sel;
        logic [2:0] pos_sel;
        logic       wr_en;
        logic [1:0] wr_sel;
        logic       len_inc;
        logic       len_dec;
        logic       emit;
        logic [1:0] emit_status;
        logic       emit_elem;
        logic       emit_last;
    } t_ole_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       len_zero;
        logic       len_one;
        logic       len_full;
        logic       idx_eq_pos;
        logic       idx_eq_last;
        logic       pvld;
        logic       match;
        logic       pidx_eq_pos;
        logic       pidx_eq_last;
    } t_ole_stat;

endpackage

FILE: hw/rtl/ole_dp.sv
// Datapath of the ordered list engine: entry memory, length, walk index,
// operand capture, search compare and result register. Uses ole_pkg.
`include "assert_macros.svh"

module ole_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ole_pkg::t_ole_in  i_item,
    input  ole_pkg::t_ole_cmd i_cmd,
    output ole_pkg::t_ole_stat o_stat,
    output ole_pkg::t_ole_out o_result,
    output logic              o_strobe
);
    import ole_pkg::*;

    logic [OLE_DW-1:0] r_mem [OLE_DEPTH];
    logic [OLE_DW-1:0] r_rd_data;
    logic [2:0]        r_op;
    logic [OLE_DW-1:0] r_value;
    logic [OLE_DW-1:0] r_target;
    logic [OLE_CW-1:0] r_len;
    logic [OLE_CW-1:0] n_len;
    logic [OLE_CW-1:0] r_idx;
    logic [OLE_CW-1:0] n_idx;
    logic [OLE_CW-1:0] r_pos;
    logic [OLE_CW-1:0] n_pos;
    logic [OLE_CW-1:0] r_pidx;
    logic              r_pvld;
    t_ole_out          r_res;
    logic              r_res_vld;

    logic [OLE_CW-1:0] len_m1;
    logic [OLE_CW-1:0] pidx_p1;
    logic [OLE_CW-1:0] pidx_m1;
    logic [OLE_AW-1:0] wr_addr;
    logic [OLE_DW-1:0] wr_data;
    logic [OLE_DW-1:0] key;

    assign len_m1  = r_len - OLE_CW'(1);
    assign pidx_p1 = r_pidx + OLE_CW'(1);
    assign pidx_m1 = r_pidx - OLE_CW'(1);
    assign key     = (r_op == OP_INSERT) ? r_target : r_value;

    // Capture the operands of an accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_item.operation;
            r_value  <= i_item.value;
            r_target <= i_item.target;
        end
    end

    // Select the write port address and data
    always_comb begin
        unique case (i_cmd.wr_sel)
            WR_UP: begin
                wr_addr = pidx_p1[OLE_AW-1:0];
                wr_data = r_rd_data;
            end
            WR_DOWN: begin
                wr_addr = pidx_m1[OLE_AW-1:0];
                wr_data = r_rd_data;
            end
            WR_VAL: begin
                wr_addr = r_pos[OLE_AW-1:0];
                wr_data = r_value;
            end
            default: begin
                wr_addr = r_pos[OLE_AW-1:0];
                wr_data = r_value;
            end
        endcase
    end

    // Entry memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[r_idx[OLE_AW-1:0]];
    end

    // Next walk index
    always_comb begin
        unique case (i_cmd.idx_sel)
            IDX_HOLD:    n_idx = r_idx;
            IDX_ZERO:    n_idx = '0;
            IDX_ONE:     n_idx = OLE_CW'(1);
            IDX_INC:     n_idx = r_idx + OLE_CW'(1);
            IDX_DEC:     n_idx = r_idx - OLE_CW'(1);
            IDX_LAST:    n_idx = len_m1;
            IDX_PIDX_P1: n_idx = pidx_p1;
            default:     n_idx = r_idx;
        endcase
    end

    // Next insert/remove position
    always_comb begin
        unique case (i_cmd.pos_sel)
            POS_HOLD:    n_pos = r_pos;
            POS_ZERO:    n_pos = '0;
            POS_LEN:     n_pos = r_len;
            POS_PIDX:    n_pos = r_pidx;
            POS_PIDX_P1: n_pos = pidx_p1;
            default:     n_pos = r_pos;
        endcase
    end

    // Next length
    always_comb begin
        n_len = r_len;
        if (i_cmd.len_inc) begin
            n_len = r_len + OLE_CW'(1);
        end else if (i_cmd.len_dec) begin
            n_len = len_m1;
        end
    end

    // Walk registers; the read tag is the index delayed by one register
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_pos  <= n_pos;
        r_pidx <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_pvld    <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_len     <= n_len;
            r_pvld    <= i_cmd.rd;
            r_res_vld <= i_cmd.emit;
        end
    end

    // Load the result register on each emit
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_res.status  <= i_cmd.emit_status;
            r_res.element <= i_cmd.emit_elem ? r_rd_data : '0;
            r_res.count   <= r_len;
            r_res.last    <= i_cmd.emit_last;
        end
    end

    // Status toward the controller
    always_comb begin
        o_stat.op           = r_op;
        o_stat.len_zero     = (r_len == '0);
        o_stat.len_one      = (r_len == OLE_CW'(1));
        o_stat.len_full     = (r_len == OLE_CW'(OLE_DEPTH));
        o_stat.idx_eq_pos   = (r_idx == r_pos);
        o_stat.idx_eq_last  = (r_idx == len_m1);
        o_stat.pvld         = r_pvld;
        o_stat.match        = (r_rd_data == key);
        o_stat.pidx_eq_pos  = (r_pidx == r_pos);
        o_stat.pidx_eq_last = (r_pidx == len_m1);
    end

    assign o_result = r_res;
    assign o_strobe = r_res_vld;

    `OLE_ASSERT_NOW(a_len_bound, i_clk, i_rst_n, 1'b1, r_len <= OLE_CW'(OLE_DEPTH))
    `OLE_ASSERT_NOW(a_inc_not_full, i_clk, i_rst_n, i_cmd.len_inc, r_len < OLE_CW'(OLE_DEPTH))
    `OLE_ASSERT_NEXT(a_dec_takes, i_clk, i_rst_n, i_cmd.len_dec && (r_len != '0), r_len == $past(len_m1))

endmodule

FILE: hw/rtl/ole_ctrl.sv
// Controller of the ordered list engine: decodes each operation and
// sequences search, shift and dump walks over the datapath. Uses ole_pkg.
`include "assert_macros.svh"

module ole_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ole_pkg::t_ole_stat i_stat,
    output ole_pkg::t_ole_cmd  o_cmd
);
    import ole_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SRCH   = 3'd2;
    localparam logic [2:0] S_SHUP   = 3'd3;
    localparam logic [2:0] S_SHDN   = 3'd4;
    localparam logic [2:0] S_WRVAL  = 3'd5;
    localparam logic [2:0] S_DUMP   = 3'd6;
    localparam logic [2:0] S_RESP   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_issue;
    logic       n_issue;
    logic [1:0] r_status;
    logic [1:0] n_status;
    t_ole_cmd   cmd;

    // Next state and datapath commands
    always_comb begin
        n_state  = r_state;
        n_issue  = r_issue;
        n_status = r_status;
        cmd      = '0;
        cmd.idx_sel = IDX_HOLD;
        cmd.pos_sel = POS_HOLD;
        cmd.wr_sel  = WR_VAL;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    cmd.capture = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_status = ST_OK;
                n_state  = S_RESP;
                unique case (i_stat.op)
                    OP_PUSH_FRONT: begin
                        if (i_stat.len_full) begin
                            n_status = ST_FULL;
                        end else begin
                            cmd.pos_sel = POS_ZERO;
                            if (i_stat.len_zero) begin
                                n_state = S_WRVAL;
                            end else begin
                                cmd.idx_sel = IDX_LAST;
                                n_issue     = 1'b1;
                                n_state     = S_SHUP;
                            end
                        end
                    end
                    OP_PUSH_BACK: begin
                        if (i_stat.len_full) begin
                            n_status = ST_FULL;
                        end else begin
                            cmd.pos_sel = POS_LEN;
                            n_state     = S_WRVAL;
                        end
                    end
                    OP_INSERT: begin
                        if (i_stat.len_zero) begin
                            n_status = ST_EMPTY;
                        end else if (i_stat.len_full) begin
                            n_status = ST_FULL;
                        end else begin
                            cmd.idx_sel = IDX_ZERO;
                            n_issue     = 1'b1;
                            n_state     = S_SRCH;
                        end
                    end
                    OP_POP_FRONT: begin
                        if (i_stat.len_zero) begin
                            n_status = ST_EMPTY;
                        end else if (i_stat.len_one) begin
                            cmd.len_dec = 1'b1;
                        end else begin
                            cmd.pos_sel = POS_ZERO;
                            cmd.idx_sel = IDX_ONE;
                            n_issue     = 1'b1;
                            n_state     = S_SHDN;
                        end
                    end
                    OP_POP_BACK: begin
                        if (i_stat.len_zero) begin
                            n_status = ST_EMPTY;
                        end else begin
                            cmd.len_dec = 1'b1;
                        end
                    end
                    OP_DELETE: begin
                        if (i_stat.len_zero) begin
                            n_status = ST_EMPTY;
                        end else begin
                            cmd.idx_sel = IDX_ZERO;
                            n_issue     = 1'b1;
                            n_state     = S_SRCH;
                        end
                    end
                    OP_DUMP: begin
                        if (i_stat.len_zero) begin
                            n_status = ST_EMPTY;
                        end else begin
                            cmd.idx_sel = IDX_ZERO;
                            n_issue     = 1'b1;
                            n_state     = S_DUMP;
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            S_SRCH: begin
                // Compare returning entries; stop issuing on the way out
                if (i_stat.pvld && i_stat.match) begin
                    if (i_stat.op == OP_INSERT) begin
                        cmd.pos_sel = POS_PIDX_P1;
                        if (i_stat.pidx_eq_last) begin
                            n_state = S_WRVAL;
                        end else begin
                            cmd.idx_sel = IDX_LAST;
                            n_issue     = 1'b1;
                            n_state     = S_SHUP;
                        end
                    end else if (i_stat.pidx_eq_last) begin
                        cmd.len_dec = 1'b1;
                        n_status    = ST_OK;
                        n_state     = S_RESP;
                    end else begin
                        cmd.pos_sel = POS_PIDX;
                        cmd.idx_sel = IDX_PIDX_P1;
                        n_issue     = 1'b1;
                        n_state     = S_SHDN;
                    end
                end else if (i_stat.pvld && i_stat.pidx_eq_last) begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_RESP;
                end else if (r_issue) begin
                    cmd.rd      = 1'b1;
                    cmd.idx_sel = IDX_INC;
                    if (i_stat.idx_eq_last) begin
                        n_issue = 1'b0;
                    end
                end
            end
            S_SHUP: begin
                // Read entry i, write it to i+1, from the back down to pos
                if (r_issue) begin
                    cmd.rd      = 1'b1;
                    cmd.idx_sel = IDX_DEC;
                    if (i_stat.idx_eq_pos) begin
                        n_issue = 1'b0;
                    end
                end
                if (i_stat.pvld) begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_UP;
                    if (i_stat.pidx_eq_pos) begin
                        n_state = S_WRVAL;
                    end
                end
            end
            S_SHDN: begin
                // Read entry i, write it to i-1, from pos+1 up to the back
                if (r_issue) begin
                    cmd.rd      = 1'b1;
                    cmd.idx_sel = IDX_INC;
                    if (i_stat.idx_eq_last) begin
                        n_issue = 1'b0;
                    end
                end
                if (i_stat.pvld) begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_DOWN;
                    if (i_stat.pidx_eq_last) begin
                        cmd.len_dec = 1'b1;
                        n_status    = ST_OK;
                        n_state     = S_RESP;
                    end
                end
            end
            S_WRVAL: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_VAL;
                cmd.len_inc = 1'b1;
                n_status    = ST_OK;
                n_state     = S_RESP;
            end
            S_DUMP: begin
                if (r_issue) begin
                    cmd.rd      = 1'b1;
                    cmd.idx_sel = IDX_INC;
                    if (i_stat.idx_eq_last) begin
                        n_issue = 1'b0;
                    end
                end
                if (i_stat.pvld) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_OK;
                    cmd.emit_elem   = 1'b1;
                    cmd.emit_last   = i_stat.pidx_eq_last;
                    if (i_stat.pidx_eq_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RESP: begin
                cmd.emit        = 1'b1;
                cmd.emit_status = r_status;
                cmd.emit_last   = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issue  <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_issue  <= n_issue;
            r_status <= n_status;
        end
    end

    assign busy  = (r_state != S_IDLE);
    assign o_cmd = cmd;

    `OLE_ASSERT_NOW(a_emit_state, i_clk, i_rst_n, cmd.emit, (r_state == S_RESP) || (r_state == S_DUMP))
    `OLE_ASSERT_NOW(a_no_wr_on_scan, i_clk, i_rst_n, cmd.wr_en, (r_state != S_SRCH) && (r_state != S_DUMP))
    `OLE_ASSERT_NEXT(a_accept_decode, i_clk, i_rst_n, start && !busy, r_state == S_DECODE)

endmodule

FILE: hw/rtl/ordered_list_engine_unit.sv
// Ordered list engine: bounded list of 16 signed 32-bit values in one entry memory.
// Search and shift walk the memory one entry per cycle through its single read port,
// so an item is not accepted before its walk is done; a dump strobes one element per cycle.
// busy drops in the cycle the last result is strobed; results cannot be stalled.
// Synchronous active-low reset empties the list; entry contents are not cleared.
module ordered_list_engine_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ole_pkg::t_ole_in  i_item,
    output ole_pkg::t_ole_out o_result,
    output logic              o_strobe
);
    import ole_pkg::*;

    t_ole_cmd  cmd;
    t_ole_stat stat;

    // Sequencer
    ole_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Storage and compare
    ole_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

endmodule
